FILE: hdl/dwl_pkg.sv
// ----------------------------------------------------------------------------
// dwl_pkg
// Shared character codes and the result word type of the word lookup engine.
// ----------------------------------------------------------------------------
package dwl_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_THREE  = 8'h33;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;

  // One result word as handed from the search sequencer to the output stage
  typedef struct packed {
    logic       pos_found;
    logic [6:0] pos_entry;
    logic       root_found;
    logic [6:0] root_entry;
    logic [2:0] root_tag_count;
    logic [7:0] root_form_count;
    logic [5:0] query_length;
    logic [7:0] entries_loaded;
  } dwl_result_t;

  function automatic logic is_form_digit(input logic [7:0] ch);
    return (ch == CH_ZERO) || (ch == CH_ONE) || (ch == CH_TWO) || (ch == CH_THREE);
  endfunction

endpackage

FILE: hdl/dwl_search.sv
// ----------------------------------------------------------------------------
// dwl_search
// Dictionary stores and the search sequencer: binary search, then a root-form
// scan, then a digit count, all through one byte comparator.
// ----------------------------------------------------------------------------
module dwl_search import dwl_pkg::*; #(
  parameter int MAX_ENTRIES    = 128,
  parameter int WORD_CHARS     = 24,
  parameter int TAGS_PER_ENTRY = 5,
  parameter int FORM_CHARS     = 128,
  parameter int QUERY_CHARS    = 32,
  localparam int CW  = $clog2(MAX_ENTRIES + 1),
  localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int WLW = $clog2(WORD_CHARS + 1),
  localparam int TCW = $clog2(TAGS_PER_ENTRY + 1),
  localparam int FLW = $clog2(FORM_CHARS + 1),
  localparam int QLW = $clog2(QUERY_CHARS + 1),
  localparam int QIW = (QUERY_CHARS > 1) ? $clog2(QUERY_CHARS) : 1,
  localparam int WAW = (MAX_ENTRIES * WORD_CHARS > 1) ? $clog2(MAX_ENTRIES * WORD_CHARS) : 1,
  localparam int FAW = (MAX_ENTRIES * FORM_CHARS > 1) ? $clog2(MAX_ENTRIES * FORM_CHARS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [QLW-1:0]   qc_i,
  input  logic [CW-1:0]    cnt_i,
  input  logic             q_we_i,
  input  logic [QIW-1:0]   q_idx_i,
  input  logic [7:0]       wr_byte_i,
  input  logic             word_we_i,
  input  logic [WAW-1:0]   word_waddr_i,
  input  logic             form_we_i,
  input  logic [FAW-1:0]   form_waddr_i,
  input  logic             meta_we_i,
  input  logic [IW-1:0]    meta_waddr_i,
  input  logic [WLW-1:0]   meta_wl_i,
  input  logic [TCW-1:0]   meta_tc_i,
  input  logic [FLW-1:0]   meta_fl_i,
  output logic             idle_o,
  output logic             res_valid_o,
  output dwl_result_t      res_o,
  input  logic             res_ack_i
);

  localparam int IXW = (QLW > WLW) ? ((QLW > FLW) ? QLW : FLW) : ((WLW > FLW) ? WLW : FLW);

  typedef enum logic [3:0] {
    S_IDLE, S_BS_TOP, S_BS_META, S_BS_RD, S_BS_CMP, S_RT_TOP, S_RT_META,
    S_SS_TOP, S_SS_RD, S_SS_CMP, S_WE_TOP, S_WE_RD, S_WE_CMP, S_FC_RD,
    S_FC_CHK, S_DONE
  } state_e;

  state_e         state_q;
  logic [CW-1:0]  lo_q, hi_q, ent_q, cnt_q;
  logic [QLW-1:0] qc_q;
  logic [IXW-1:0] i_q;
  logic [FLW:0]   s_q;
  logic [WLW-1:0] wl_q;
  logic [TCW-1:0] tc_q;
  logic [FLW-1:0] fl_q, fc_q;
  logic           pf_q, rf_q;
  logic [IW-1:0]  pe_q, re_q;

  // Stores
  logic [7:0]     q_mem    [QUERY_CHARS];
  logic [7:0]     word_mem [MAX_ENTRIES * WORD_CHARS];
  logic [7:0]     form_mem [MAX_ENTRIES * FORM_CHARS];
  logic [WLW-1:0] wl_mem   [MAX_ENTRIES];
  logic [TCW-1:0] tc_mem   [MAX_ENTRIES];
  logic [FLW-1:0] fl_mem   [MAX_ENTRIES];

  logic [7:0]     word_rd_q, form_rd_q;
  logic [WLW-1:0] wl_rd_q;
  logic [TCW-1:0] tc_rd_q;
  logic [FLW-1:0] fl_rd_q;

  logic [WAW-1:0] word_raddr;
  logic [FAW-1:0] form_raddr;
  logic [IW-1:0]  meta_raddr;
  logic [CW:0]    mid_sum;
  logic [CW-1:0]  mid;

  assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid        = mid_sum[CW:1];
  assign word_raddr = WAW'(32'(ent_q) * WORD_CHARS + 32'(i_q));
  assign form_raddr = FAW'(32'(ent_q) * FORM_CHARS + 32'(s_q) + 32'(i_q));
  assign meta_raddr = (state_q == S_BS_TOP) ? mid[IW-1:0] : ent_q[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (q_we_i) q_mem[q_idx_i] <= wr_byte_i;
  end

  always_ff @(posedge clk_i) begin
    if (word_we_i) word_mem[word_waddr_i] <= wr_byte_i;
    word_rd_q <= word_mem[word_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (form_we_i) form_mem[form_waddr_i] <= wr_byte_i;
    form_rd_q <= form_mem[form_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (meta_we_i) begin
      wl_mem[meta_waddr_i] <= meta_wl_i;
      tc_mem[meta_waddr_i] <= meta_tc_i;
      fl_mem[meta_waddr_i] <= meta_fl_i;
    end
    wl_rd_q <= wl_mem[meta_raddr];
    tc_rd_q <= tc_mem[meta_raddr];
    fl_rd_q <= fl_mem[meta_raddr];
  end

  // Shared byte comparator: query byte against the byte just read
  logic [7:0] q_byte, rd_byte;
  logic       byte_eq, byte_lt, i_lt_qc, i_lt_wl, i_lt_fl;

  assign q_byte  = q_mem[i_q[QIW-1:0]];
  assign rd_byte = (state_q == S_SS_CMP || state_q == S_FC_CHK) ? form_rd_q : word_rd_q;
  assign byte_eq = (q_byte == rd_byte);
  assign byte_lt = (q_byte < rd_byte);
  assign i_lt_qc = 32'(i_q) < 32'(qc_q);
  assign i_lt_wl = 32'(i_q) < 32'(wl_q);
  assign i_lt_fl = 32'(i_q) < 32'(fl_q);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lo_q    <= '0;
      hi_q    <= '0;
      ent_q   <= '0;
      cnt_q   <= '0;
      qc_q    <= '0;
      i_q     <= '0;
      s_q     <= '0;
      wl_q    <= '0;
      tc_q    <= '0;
      fl_q    <= '0;
      fc_q    <= '0;
      pf_q    <= 1'b0;
      rf_q    <= 1'b0;
      pe_q    <= '0;
      re_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            qc_q    <= qc_i;
            cnt_q   <= cnt_i;
            lo_q    <= '0;
            hi_q    <= cnt_i;
            pf_q    <= 1'b0;
            pe_q    <= '0;
            rf_q    <= 1'b0;
            re_q    <= '0;
            fc_q    <= '0;
            state_q <= S_BS_TOP;
          end
        end
        S_BS_TOP: begin
          if (lo_q < hi_q) begin
            ent_q   <= mid;
            state_q <= S_BS_META;
          end else begin
            ent_q   <= '0;
            state_q <= S_RT_TOP;
          end
        end
        S_BS_META: begin
          wl_q    <= wl_rd_q;
          i_q     <= '0;
          state_q <= S_BS_RD;
        end
        S_BS_RD: begin
          if (i_lt_qc && i_lt_wl) begin
            state_q <= S_BS_CMP;
          end else if (32'(qc_q) == 32'(wl_q)) begin
            pf_q    <= 1'b1;
            pe_q    <= ent_q[IW-1:0];
            ent_q   <= '0;
            state_q <= S_RT_TOP;
          end else if (32'(qc_q) < 32'(wl_q)) begin
            hi_q    <= ent_q;
            state_q <= S_BS_TOP;
          end else begin
            lo_q    <= ent_q + 1'b1;
            state_q <= S_BS_TOP;
          end
        end
        S_BS_CMP: begin
          if (byte_eq) begin
            i_q     <= i_q + 1'b1;
            state_q <= S_BS_RD;
          end else if (byte_lt) begin
            hi_q    <= ent_q;
            state_q <= S_BS_TOP;
          end else begin
            lo_q    <= ent_q + 1'b1;
            state_q <= S_BS_TOP;
          end
        end
        S_RT_TOP: begin
          if (ent_q < cnt_q) state_q <= S_RT_META;
          else               state_q <= S_DONE;
        end
        S_RT_META: begin
          wl_q    <= wl_rd_q;
          tc_q    <= tc_rd_q;
          fl_q    <= fl_rd_q;
          s_q     <= '0;
          state_q <= S_SS_TOP;
        end
        // substring search of the query in the form string
        S_SS_TOP: begin
          i_q <= '0;
          if (32'(s_q) + 32'(qc_q) <= 32'(fl_q)) state_q <= S_SS_RD;
          else                                   state_q <= S_WE_TOP;
        end
        S_SS_RD: begin
          if (i_lt_qc) begin
            state_q <= S_SS_CMP;
          end else begin
            rf_q    <= 1'b1;
            re_q    <= ent_q[IW-1:0];
            s_q     <= '0;
            i_q     <= '0;
            state_q <= S_FC_RD;
          end
        end
        S_SS_CMP: begin
          if (byte_eq) begin
            i_q     <= i_q + 1'b1;
            state_q <= S_SS_RD;
          end else begin
            s_q     <= s_q + 1'b1;
            state_q <= S_SS_TOP;
          end
        end
        // exact word match
        S_WE_TOP: begin
          i_q <= '0;
          if (32'(wl_q) == 32'(qc_q)) begin
            state_q <= S_WE_RD;
          end else begin
            ent_q   <= ent_q + 1'b1;
            state_q <= S_RT_TOP;
          end
        end
        S_WE_RD: begin
          if (i_lt_qc) begin
            state_q <= S_WE_CMP;
          end else begin
            rf_q    <= 1'b1;
            re_q    <= ent_q[IW-1:0];
            s_q     <= '0;
            i_q     <= '0;
            state_q <= S_FC_RD;
          end
        end
        S_WE_CMP: begin
          if (byte_eq) begin
            i_q     <= i_q + 1'b1;
            state_q <= S_WE_RD;
          end else begin
            ent_q   <= ent_q + 1'b1;
            state_q <= S_RT_TOP;
          end
        end
        // count form markers of the root entry
        S_FC_RD: begin
          if (i_lt_fl) state_q <= S_FC_CHK;
          else         state_q <= S_DONE;
        end
        S_FC_CHK: begin
          if (is_form_digit(rd_byte)) fc_q <= fc_q + 1'b1;
          i_q     <= i_q + 1'b1;
          state_q <= S_FC_RD;
        end
        S_DONE: begin
          if (res_ack_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.pos_found       = pf_q;
    res_o.pos_entry       = 7'(32'(pe_q));
    res_o.root_found      = rf_q;
    res_o.root_entry      = 7'(32'(re_q));
    res_o.root_tag_count  = rf_q ? 3'(32'(tc_q)) : 3'd0;
    res_o.root_form_count = 8'(32'(fc_q));
    res_o.query_length    = 6'(32'(qc_q));
    res_o.entries_loaded  = 8'(32'(cnt_q));
  end

endmodule

FILE: hdl/dictionary_word_lookup_engine.sv
// ----------------------------------------------------------------------------
// dictionary_word_lookup_engine
// Stream parser, dictionary search sequencer and result output register.
// ----------------------------------------------------------------------------
// Every dictionary byte and every query letter is taken at one per cycle
// while the search sequencer is idle. A space (or end_of_input) after a query
// starts a search, and no byte is taken until it is done. The search compares
// characters through the single byte comparator and its registered store
// reads: binary search steps, then a scan of the entries with every start
// position tried in each form string, then a pass over the form bytes of
// the root entry for the marker count. The root-form scan over the form
// strings takes the longest. A finished result waits in the output register
// while the next bytes are taken.
module dictionary_word_lookup_engine import dwl_pkg::*; #(
  parameter int MAX_ENTRIES    = 128,
  parameter int WORD_CHARS     = 24,
  parameter int TAGS_PER_ENTRY = 5,
  parameter int FORM_CHARS     = 128,
  parameter int QUERY_CHARS    = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       pos_found_o,
  output logic [6:0] pos_entry_o,
  output logic       root_found_o,
  output logic [6:0] root_entry_o,
  output logic [2:0] root_tag_count_o,
  output logic [7:0] root_form_count_o,
  output logic [5:0] query_length_o,
  output logic [7:0] entries_loaded_o
);

  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int WLW = $clog2(WORD_CHARS + 1);
  localparam int TCW = $clog2(TAGS_PER_ENTRY + 1);
  localparam int FLW = $clog2(FORM_CHARS + 1);
  localparam int QLW = $clog2(QUERY_CHARS + 1);
  localparam int QIW = (QUERY_CHARS > 1) ? $clog2(QUERY_CHARS) : 1;
  localparam int WAW = (MAX_ENTRIES * WORD_CHARS > 1) ? $clog2(MAX_ENTRIES * WORD_CHARS) : 1;
  localparam int FAW = (MAX_ENTRIES * FORM_CHARS > 1) ? $clog2(MAX_ENTRIES * FORM_CHARS) : 1;

  typedef enum logic [2:0] {
    PH_IDLE, PH_WORD, PH_TAGS, PH_FORM, PH_QUERY, PH_SKIP
  } phase_e;

  phase_e         phase_q, phase_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [WLW-1:0] wl_q, wl_d;
  logic [TCW-1:0] tc_q, tc_d;
  logic [FLW-1:0] fl_q, fl_d;
  logic [QLW-1:0] qc_q, qc_d;
  logic           out_valid_q;
  dwl_result_t    out_q;

  logic           acc, start, q_we, word_we, form_we, meta_we;
  logic           is_letter;
  logic [IW-1:0]  cur_e;
  logic           srch_idle, res_valid, res_ack;
  dwl_result_t    res;

  assign acc        = in_valid_i && in_ready_o;
  assign in_ready_o = srch_idle;
  assign is_letter  = ((in_byte_i >= CH_UC_A) && (in_byte_i <= CH_UC_Z)) ||
                      ((in_byte_i >= CH_LC_A) && (in_byte_i <= CH_LC_Z));
  assign cur_e      = IW'(32'(cnt_q) - 32'd1);

  // Stream parser
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    wl_d    = wl_q;
    tc_d    = tc_q;
    fl_d    = fl_q;
    qc_d    = qc_q;
    start   = 1'b0;
    q_we    = 1'b0;
    word_we = 1'b0;
    form_we = 1'b0;
    if (acc) begin
      if (end_of_input_i) begin
        start   = (phase_q == PH_QUERY);
        phase_d = PH_IDLE;
        cnt_d   = '0;
        qc_d    = '0;
      end else if (phase_q == PH_QUERY) begin
        if (is_letter) begin
          if (32'(qc_q) < QUERY_CHARS) begin
            q_we = 1'b1;
            qc_d = qc_q + 1'b1;
          end
        end else if (in_byte_i == CH_SPACE) begin
          start = 1'b1;
          qc_d  = '0;
        end
      end else if (in_byte_i == CH_STAR) begin
        phase_d = PH_QUERY;
        qc_d    = '0;
      end else if (in_byte_i == CH_DOLLAR) begin
        if (32'(cnt_q) < MAX_ENTRIES) begin
          cnt_d   = cnt_q + 1'b1;
          wl_d    = '0;
          tc_d    = '0;
          fl_d    = '0;
          phase_d = PH_WORD;
        end else begin
          phase_d = PH_SKIP;
        end
      end else if (phase_q != PH_IDLE && phase_q != PH_SKIP && cnt_q != '0) begin
        if (in_byte_i == CH_NL) begin
          if (phase_q == PH_WORD) phase_d = PH_TAGS;
        end else if (in_byte_i == CH_SPACE || in_byte_i == CH_HASH) begin
          if (32'(tc_q) < TAGS_PER_ENTRY) tc_d = tc_q + 1'b1;
          if (phase_q == PH_WORD) begin
            wl_d = '0;
          end else if (in_byte_i == CH_HASH) begin
            phase_d = PH_FORM;
            fl_d    = '0;
          end else begin
            phase_d = PH_TAGS;
          end
        end else if (phase_q == PH_WORD) begin
          if (32'(wl_q) < WORD_CHARS) begin
            word_we = 1'b1;
            wl_d    = wl_q + 1'b1;
          end
        end else if (phase_q == PH_FORM) begin
          if (32'(fl_q) < FORM_CHARS) begin
            form_we = 1'b1;
            fl_d    = fl_q + 1'b1;
          end
        end
      end
    end
  end

  // Entry metadata follows every change of the open entry
  assign meta_we = acc && !end_of_input_i &&
                   (phase_d == PH_WORD || phase_d == PH_TAGS || phase_d == PH_FORM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      wl_q    <= '0;
      tc_q    <= '0;
      fl_q    <= '0;
      qc_q    <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      wl_q    <= wl_d;
      tc_q    <= tc_d;
      fl_q    <= fl_d;
      qc_q    <= qc_d;
    end
  end

  dwl_search #(
    .MAX_ENTRIES   (MAX_ENTRIES),
    .WORD_CHARS    (WORD_CHARS),
    .TAGS_PER_ENTRY(TAGS_PER_ENTRY),
    .FORM_CHARS    (FORM_CHARS),
    .QUERY_CHARS   (QUERY_CHARS)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .qc_i        (qc_q),
    .cnt_i       (cnt_q),
    .q_we_i      (q_we),
    .q_idx_i     (qc_q[QIW-1:0]),
    .wr_byte_i   (in_byte_i),
    .word_we_i   (word_we),
    .word_waddr_i(WAW'(32'(cur_e) * WORD_CHARS + 32'(wl_q))),
    .form_we_i   (form_we),
    .form_waddr_i(FAW'(32'(cur_e) * FORM_CHARS + 32'(fl_q))),
    .meta_we_i   (meta_we),
    .meta_waddr_i(IW'(32'(cnt_d) - 32'd1)),
    .meta_wl_i   (wl_d),
    .meta_tc_i   (tc_d),
    .meta_fl_i   (fl_d),
    .idle_o      (srch_idle),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ack_i   (res_ack)
  );

  // Output register
  assign res_ack = res_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ack) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack) out_q <= res;
  end

  assign out_valid_o       = out_valid_q;
  assign pos_found_o       = out_q.pos_found;
  assign pos_entry_o       = out_q.pos_entry;
  assign root_found_o      = out_q.root_found;
  assign root_entry_o      = out_q.root_entry;
  assign root_tag_count_o  = out_q.root_tag_count;
  assign root_form_count_o = out_q.root_form_count;
  assign query_length_o    = out_q.query_length;
  assign entries_loaded_o  = out_q.entries_loaded;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_ENTRIES) else $error("entry count beyond capacity");

  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !in_ready_o) else $error("search did not start on finished query");

  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !pos_found_o) |-> (pos_entry_o == 7'd0))
    else $error("pos entry set without a match");

  a_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !root_found_o) |->
    (root_entry_o == 7'd0 && root_tag_count_o == 3'd0 && root_form_count_o == 8'd0))
    else $error("root fields set without a match");
`endif

endmodule
